// ===== sv/signed_value_to_seven_segment_defines.svh =====
// Assertion macros for the signed value to seven-segment block.
// Used by the top level only; expects clk and rst in scope.
`ifndef SIGNED_VALUE_TO_SEVEN_SEGMENT_DEFINES_SVH
`define SIGNED_VALUE_TO_SEVEN_SEGMENT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SVSEG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("svseg same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define SVSEG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("svseg next-cycle check failed");

`endif

// ===== sv/svseg_pkg.sv =====
// Package for the signed value to seven-segment block: word types, glyph
// constants and the conversion functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package svseg_pkg;

  localparam int MAG_W = 14;
  localparam int BCD_W = 16;

  localparam logic [MAG_W-1:0] MAX_SHOWN   = MAG_W'(9999);
  localparam logic [7:0]       MINUS_GLYPH = 8'h40;
  localparam logic [7:0]       DOT_BIT     = 8'h80;

  typedef struct packed {
    logic signed [15:0] value;
    logic               decimal_point;
  } svseg_in_t;

  typedef struct packed {
    logic [7:0] digit0_segments;
    logic [7:0] digit1_segments;
    logic [7:0] digit2_segments;
    logic [7:0] digit3_segments;
  } svseg_out_t;

  function automatic logic [7:0] glyph(input logic [3:0] nib);
    logic [7:0] g;
    unique case (nib)
      4'h0: g = 8'h3F;
      4'h1: g = 8'h06;
      4'h2: g = 8'h5B;
      4'h3: g = 8'h4F;
      4'h4: g = 8'h66;
      4'h5: g = 8'h6D;
      4'h6: g = 8'h7D;
      4'h7: g = 8'h07;
      4'h8: g = 8'h7F;
      4'h9: g = 8'h6F;
      4'hA: g = 8'h5F;
      4'hB: g = 8'h7C;
      4'hC: g = 8'h58;
      4'hD: g = 8'h5E;
      4'hE: g = 8'h7B;
      4'hF: g = 8'h71;
    endcase
    return g;
  endfunction

  // Segments a..c trade places with d..f; middle and dot stay.
  function automatic logic [7:0] rotate_glyph(input logic [7:0] a);
    return {a[7:6], a[2:0], a[5:3]};
  endfunction

  // Shift-and-add-3 over a magnitude that is already below 10000.
  function automatic logic [BCD_W-1:0] to_bcd(input logic [MAG_W-1:0] bin);
    logic [BCD_W-1:0] bcd;
    bcd = '0;
    for (int i = 0; i < MAG_W; i++) begin
      for (int k = 0; k < BCD_W / 4; k++) begin
        if (bcd[4*k +: 4] >= 4'd5) begin
          bcd[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
        end
      end
      bcd = {bcd[BCD_W-2:0], bin[MAG_W-1-i]};
    end
    return bcd;
  endfunction

endpackage

`default_nettype wire

// ===== sv/signed_value_to_seven_segment.sv =====
// Signed value to four seven-segment bytes, with optional 180-degree flip.
// Each accepted word is held in the input register, then in the result register.
// Throughput: one word per cycle; the input register and the result register
// form a two-stage pipeline that advances whenever the result side can take.
// Reset (synchronous, rst high) empties both stages and clears flip_180.
`timescale 1ns / 1ps
`default_nettype none
`include "signed_value_to_seven_segment_defines.svh"

module signed_value_to_seven_segment
  import svseg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic       cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire svseg_in_t  in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output svseg_out_t      out_data
);

  logic             flip_180;

  logic             s1_valid;
  logic             s1_neg;
  logic             s1_dp;
  logic [MAG_W-1:0] s1_mag;

  logic             advance;
  logic             neg_in;
  logic [15:0]      mag_in;
  logic [MAG_W-1:0] sat_in;

  logic [BCD_W-1:0] bcd;
  logic [7:0]       d0, d1, d2, d3;
  svseg_out_t       out_data_next;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  // Magnitude of -32768 is 0x8000 as an unsigned 16-bit value.
  assign neg_in = in_data.value[15];
  assign mag_in = neg_in ? 16'(-in_data.value) : 16'(in_data.value);
  assign sat_in = (mag_in > 16'(MAX_SHOWN)) ? MAX_SHOWN : mag_in[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      flip_180 <= 1'b0;
    end else if (cfg_write) begin
      flip_180 <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_neg <= neg_in;
      s1_dp  <= in_data.decimal_point;
      s1_mag <= sat_in;
    end
  end

  always_comb begin
    bcd = to_bcd(s1_mag);
    d0  = s1_neg ? MINUS_GLYPH : glyph(bcd[15:12]);
    d1  = glyph(bcd[11:8]) | (s1_dp ? DOT_BIT : 8'h00);
    d2  = glyph(bcd[7:4]);
    d3  = glyph(bcd[3:0]);
    if (flip_180) begin
      out_data_next.digit0_segments = rotate_glyph(d3);
      out_data_next.digit1_segments = rotate_glyph(d2);
      out_data_next.digit2_segments = rotate_glyph(d1);
      out_data_next.digit3_segments = rotate_glyph(d0);
    end else begin
      out_data_next.digit0_segments = d0;
      out_data_next.digit1_segments = d1;
      out_data_next.digit2_segments = d2;
      out_data_next.digit3_segments = d3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_data <= out_data_next;
    end
  end

  `SVSEG_ASSERT_NEXT(a_stage_moves, advance && s1_valid, out_valid)
  `SVSEG_ASSERT_NEXT(a_stage_holds, s1_valid && !advance, s1_valid)
  `SVSEG_ASSERT_NEXT(a_minus_left, advance && s1_valid && s1_neg && !flip_180,
                     out_data.digit0_segments == MINUS_GLYPH)
  `SVSEG_ASSERT_NOW(a_outer_no_dot, out_valid,
                    !out_data.digit0_segments[7] && !out_data.digit3_segments[7])

endmodule

`default_nettype wire

// ===== verif/svseg_checker.sv =====
// Checker for the signed value to seven-segment block: watches both channels,
// predicts the four segment bytes of every accepted word and compares them.
// Depends on svseg_pkg for the word types and glyph constants.
`timescale 1ns / 1ps

module svseg_checker
  import svseg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  svseg_in_t  in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  svseg_out_t out_data,
  output int         fail_count,
  output int         pending
);

  // Segment patterns of the decimal digits, digit 0 in the lowest byte.
  localparam logic [79:0] DIGIT_FONT = {
    8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };
  localparam int LARGEST_SHOWN = 9999;

  svseg_out_t segments_q[$];
  logic       flip_shadow = 1'b0;
  int         errors = 0;

  function automatic logic [7:0] digit_font(input int d);
    return DIGIT_FONT[8*d +: 8];
  endfunction

  // Turning the display over swaps the upper and lower three outer segments.
  function automatic logic [7:0] upside_down(input logic [7:0] x);
    return (x & 8'hC0) | ((x & 8'h07) << 3) | ((x >> 3) & 8'h07);
  endfunction

  function automatic svseg_out_t predict_segments(input svseg_in_t w, input logic flip);
    logic [16:0] mag;
    int          shown;
    logic [7:0]  d0, d1, d2, d3;
    svseg_out_t  r;
    mag = w.value[15] ? (17'h10000 - {1'b0, w.value}) : {1'b0, w.value};
    shown = (mag > LARGEST_SHOWN) ? LARGEST_SHOWN : int'(mag);
    // A negative value gives up its thousands digit to the minus sign.
    d0 = w.value[15] ? MINUS_GLYPH : digit_font(shown / 1000);
    d1 = digit_font((shown / 100) % 10) | (w.decimal_point ? DOT_BIT : 8'h00);
    d2 = digit_font((shown / 10) % 10);
    d3 = digit_font(shown % 10);
    if (flip) begin
      r.digit0_segments = upside_down(d3);
      r.digit1_segments = upside_down(d2);
      r.digit2_segments = upside_down(d1);
      r.digit3_segments = upside_down(d0);
    end else begin
      r.digit0_segments = d0;
      r.digit1_segments = d1;
      r.digit2_segments = d2;
      r.digit3_segments = d3;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    svseg_out_t want;
    if (rst) begin
      flip_shadow = 1'b0;
      segments_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        segments_q.push_back(predict_segments(in_data, flip_shadow));
      end
      if (cfg_write) begin
        flip_shadow = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (segments_q.size() == 0) begin
          if (errors < 10) begin
            $display("%0t: result word %h arrived with nothing expected", $realtime, out_data);
          end
          errors++;
        end else begin
          want = segments_q.pop_front();
          if (want.digit0_segments !== out_data.digit0_segments ||
              want.digit1_segments !== out_data.digit1_segments ||
              want.digit2_segments !== out_data.digit2_segments ||
              want.digit3_segments !== out_data.digit3_segments) begin
            if (errors < 10) begin
              $display("%0t: segments expected %h %h %h %h, got %h %h %h %h", $realtime,
                       want.digit0_segments, want.digit1_segments,
                       want.digit2_segments, want.digit3_segments,
                       out_data.digit0_segments, out_data.digit1_segments,
                       out_data.digit2_segments, out_data.digit3_segments);
            end
            errors++;
          end
        end
      end
    end
    pending    <= segments_q.size();
    fail_count <= errors;
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the signed value to seven-segment block: clock, reset,
// flip register writes and input words with random idling on both sides.
// Depends on svseg_pkg, the block itself and svseg_checker.
`timescale 1ns / 1ps

module tb;
  import svseg_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  svseg_in_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  svseg_out_t out_data;
  int         fail_count;
  int         pending;
  bit         calm = 1'b0;

  logic signed [15:0] corner_values [12] = '{
    16'sd0, 16'sd1234, -16'sd1234, 16'sd9999, 16'sd10000, -16'sd9999,
    -16'sd10000, 16'sd32767, -16'sd32768, 16'sd5678, -16'sd7, 16'sd8090
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  signed_value_to_seven_segment i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  svseg_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_word(input logic signed [15:0] v, input logic dp);
    if (!calm) begin
      while ($urandom_range(99) < 8) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= {v, dp};
    do @(posedge clk); while (!in_ready);
  endtask

  // The pipeline is two stages deep; the task goes on waiting after nothing is pending to cover any stray word.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_flip(input logic f);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data  <= f;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Mix of in-range values, raw 16-bit values, values near the saturation
  // and sign edges and values near the 16-bit extremes.
  function automatic logic signed [15:0] pick_value();
    int sel;
    int base;
    sel = $urandom_range(9);
    if (sel <= 2) begin
      return 16'($urandom_range(19998) - 9999);
    end else if (sel <= 4) begin
      return 16'($urandom());
    end else if (sel <= 6) begin
      return 16'($urandom_range(9999));
    end else if (sel <= 8) begin
      base = ($urandom_range(1) != 0) ? 10000 : 1;
      base = base + $urandom_range(2) - 1;
      return 16'(($urandom_range(1) != 0) ? -base : base);
    end else begin
      return ($urandom_range(1) != 0) ? 16'(16'h8000 + $urandom_range(3))
                                      : 16'(16'h7FFF - $urandom_range(3));
    end
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    write_flip(1'b0);
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        write_flip(1'b1);
      end
      for (int i = 0; i < 12; i++) begin
        send_word(corner_values[i], logic'((i + pass) % 2));
      end
    end
    for (int ph = 0; ph < 6; ph++) begin
      write_flip(logic'(ph % 2));
      calm = (ph == 3);
      for (int n = 0; n < 75; n++) begin
        if (ph == 2 && n == 37) begin
          wait_drained();
        end
        send_word(pick_value(), logic'($urandom_range(1)));
      end
    end
    calm = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/svseg_pkg.sv
sv/signed_value_to_seven_segment.sv
verif/svseg_checker.sv
verif/tb.sv
